// ===== sv/rde_pkg.sv =====
// Shared constants, types and state codes for the reversible deque engine.
package rde_pkg;

  localparam int DEPTH = 64;
  localparam int DATA_W = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_TOGGLE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_DRAIN  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_ELEM     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ERROR    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STATUS,
    BK_READ,
    BK_LAND
  } back_state_t;

  typedef struct packed {
    action_t             action;
    logic [DATA_W-1:0]   value;
  } cmd_t;

endpackage

// ===== sv/rde_if.sv =====
// Handshake interfaces for the command and response channels.
interface rde_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [rde_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface rde_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [rde_pkg::DATA_W-1:0] element;
  logic                       last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink (input valid, input status, input element, input last, output ready);
endinterface

// ===== sv/reversible_deque_engine_unit.sv =====
// Reversible deque engine: a 64-entry ring-buffer deque of 16-bit elements with a
// lazy reverse flag. Commands are taken one per cycle while the front register is
// free or the two-entry command queue has room; append, toggle and delete are each
// handled in the idle state of the back end. A drain is taken from the queue in the
// idle state; then for each element the back end makes a registered read of the
// element RAM and loads the output register, each read waiting until the output
// register is free. A drain that reports empty, error or overflow passes through the
// status state, which loads the report once the output register is free.
// Commands that follow a drain wait in the queue until the drain has finished. All
// state is cleared after each drain; no clearing pass is needed after reset.
module reversible_deque_engine_unit (
  input logic       clk,
  input logic       rst,
  rde_cmd_if.sink   cmd,
  rde_rsp_if.source rsp
);

  logic          f_push;
  rde_pkg::cmd_t f_cmd;
  logic          f_ready;
  logic          q_valid;
  rde_pkg::cmd_t q_cmd;
  logic          q_pop;

  rde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push       (f_push),
    .push_cmd   (f_cmd),
    .push_ready (f_ready)
  );

  rde_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  rde_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

// ===== sv/rde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rde_front.sv =====
// Front end: takes command beats, decodes the action and holds one item for the queue.
module rde_front (
  input  logic          clk,
  input  logic          rst,
  rde_cmd_if.sink       cmd,
  output logic          push,
  output rde_pkg::cmd_t push_cmd,
  input  logic          push_ready
);

  logic          hold_valid;
  rde_pkg::cmd_t hold;
  rde_pkg::cmd_t decoded;
  logic          accept;

  assign cmd.ready = !hold_valid || push_ready;
  assign accept    = cmd.valid && cmd.ready;

  // Only appends carry a value; other actions pass zero downstream.
  always_comb begin
    decoded.action = rde_pkg::action_t'(cmd.action);
    decoded.value  = (decoded.action == rde_pkg::ACT_APPEND) ? cmd.value
                                                              : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= decoded;
    end
  end

  assign push     = hold_valid;
  assign push_cmd = hold;

endmodule

// ===== sv/rde_cmd_fifo.sv =====
// Short command queue between the front end and the deque back end.
module rde_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rde_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output rde_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  rde_pkg::cmd_t                       entries [rde_pkg::FIFO_DEPTH];
  logic [rde_pkg::FIFO_PTR_W-1:0]      wptr;
  logic [rde_pkg::FIFO_PTR_W-1:0]      rptr;
  logic [rde_pkg::FIFO_CNT_W-1:0]      fill;
  logic                                do_push;
  logic                                do_pop;

  assign push_ready = fill != rde_pkg::FIFO_CNT_W'(rde_pkg::FIFO_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [rde_pkg::FIFO_PTR_W-1:0] bump(
    input logic [rde_pkg::FIFO_PTR_W-1:0] p
  );
    if (p == rde_pkg::FIFO_PTR_W'(rde_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + rde_pkg::FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= bump(wptr);
      end
      if (do_pop) begin
        rptr <= bump(rptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + rde_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - rde_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

// ===== sv/rde_back.sv =====
// Back end: deque pointers and flags, element RAM, drain sequencer and output register.
module rde_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rde_pkg::cmd_t q_cmd,
  output logic          q_pop,
  rde_rsp_if.source     rsp
);

  rde_pkg::back_state_t           state;
  rde_pkg::back_state_t           state_next;
  logic [rde_pkg::PTR_W-1:0]      head;
  logic [rde_pkg::CNT_W-1:0]      count;
  logic                           reverse;
  logic                           error;
  logic                           overflow;
  logic [rde_pkg::PTR_W-1:0]      idx;

  logic                           out_valid;
  rde_pkg::status_t               out_status;
  logic [rde_pkg::DATA_W-1:0]     out_element;
  logic                           out_last;

  logic                           out_free;
  logic                           faulted_or_empty;
  logic                           last_elem;
  logic                           is_drain;
  logic                           load_status;
  logic                           load_elem;
  logic                           clear;
  logic                           rd_en;
  logic                           we;
  logic [rde_pkg::PTR_W-1:0]      waddr;
  logic [rde_pkg::PTR_W-1:0]      raddr;
  logic [rde_pkg::CNT_W-1:0]      rd_off;
  logic [rde_pkg::DATA_W-1:0]     rd_data;
  rde_pkg::status_t               fault_status;

  // Physical slot of a logical offset from the head, with one wrap at most.
  function automatic logic [rde_pkg::PTR_W-1:0] slot_of(
    input logic [rde_pkg::PTR_W-1:0] h,
    input logic [rde_pkg::CNT_W-1:0] o
  );
    logic [rde_pkg::CNT_W:0] s;
    s = (rde_pkg::CNT_W+1)'(h) + (rde_pkg::CNT_W+1)'(o);
    if (s >= (rde_pkg::CNT_W+1)'(rde_pkg::DEPTH)) begin
      s = s - (rde_pkg::CNT_W+1)'(rde_pkg::DEPTH);
    end
    return s[rde_pkg::PTR_W-1:0];
  endfunction

  assign out_free         = !out_valid || rsp.ready;
  assign faulted_or_empty = error || overflow || (count == '0);
  assign last_elem        = (rde_pkg::CNT_W'(idx) + rde_pkg::CNT_W'(1)) == count;
  assign is_drain         = q_valid && (q_cmd.action == rde_pkg::ACT_DRAIN);

  always_comb begin
    if (error) begin
      fault_status = rde_pkg::ST_ERROR;
    end else if (overflow) begin
      fault_status = rde_pkg::ST_OVERFLOW;
    end else begin
      fault_status = rde_pkg::ST_EMPTY;
    end
  end

  // With the reverse flag set, the logical order runs backward from the tail.
  assign rd_off = reverse ? (count - rde_pkg::CNT_W'(1) - rde_pkg::CNT_W'(idx))
                          : rde_pkg::CNT_W'(idx);
  assign raddr  = slot_of(head, rd_off);
  assign waddr  = slot_of(head, count);
  assign we     = q_pop && (q_cmd.action == rde_pkg::ACT_APPEND)
                  && (count < rde_pkg::CNT_W'(rde_pkg::DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      rde_pkg::BK_IDLE: begin
        if (is_drain) begin
          state_next = faulted_or_empty ? rde_pkg::BK_STATUS : rde_pkg::BK_READ;
        end
      end
      rde_pkg::BK_STATUS: begin
        if (out_free) begin
          state_next = rde_pkg::BK_IDLE;
        end
      end
      rde_pkg::BK_READ: begin
        if (out_free) begin
          state_next = rde_pkg::BK_LAND;
        end
      end
      rde_pkg::BK_LAND: begin
        state_next = last_elem ? rde_pkg::BK_IDLE : rde_pkg::BK_READ;
      end
      default: begin
        state_next = rde_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    load_status = 1'b0;
    load_elem   = 1'b0;
    clear       = 1'b0;
    case (state)
      rde_pkg::BK_IDLE: begin
        q_pop = q_valid;
      end
      rde_pkg::BK_STATUS: begin
        load_status = out_free;
        clear       = out_free;
      end
      rde_pkg::BK_READ: begin
        rd_en = out_free;
      end
      rde_pkg::BK_LAND: begin
        load_elem = 1'b1;
        clear     = last_elem;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rde_pkg::BK_IDLE;
      head      <= '0;
      count     <= '0;
      reverse   <= 1'b0;
      error     <= 1'b0;
      overflow  <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_status || load_elem) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (load_elem && !clear) begin
        idx <= idx + rde_pkg::PTR_W'(1);
      end
      if (clear) begin
        head     <= '0;
        count    <= '0;
        reverse  <= 1'b0;
        error    <= 1'b0;
        overflow <= 1'b0;
        idx      <= '0;
      end else if (q_pop) begin
        case (q_cmd.action)
          rde_pkg::ACT_APPEND: begin
            if (we) begin
              count <= count + rde_pkg::CNT_W'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
          rde_pkg::ACT_TOGGLE: begin
            if (!error) begin
              reverse <= !reverse;
            end
          end
          rde_pkg::ACT_DELETE: begin
            if (!error) begin
              if (count == '0) begin
                error <= 1'b1;
              end else begin
                if (!reverse) begin
                  head <= slot_of(head, rde_pkg::CNT_W'(1));
                end
                count <= count - rde_pkg::CNT_W'(1);
              end
            end
          end
          default: begin
            idx <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_status  <= fault_status;
      out_element <= '0;
      out_last    <= 1'b1;
    end else if (load_elem) begin
      out_status  <= rde_pkg::ST_ELEM;
      out_element <= rd_data;
      out_last    <= last_elem;
    end
  end

  rde_ram #(
    .WIDTH (rde_pkg::DATA_W),
    .DEPTH (rde_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_cmd.value),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.element = out_element;
  assign rsp.last    = out_last;

endmodule

// ===== sv/rde_checker.sv =====
// Port-level checks on the response channel of the deque engine, bound to the top level.
module rde_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [1:0]                 rsp_status,
  input logic [rde_pkg::DATA_W-1:0] rsp_element,
  input logic                       rsp_last
);

  // A stalled response beat keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_element) && $stable(rsp_last))
    else $error("response beat changed while stalled");

  // A status report always stands alone as the end of its drain.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != rde_pkg::ST_ELEM |-> rsp_last)
    else $error("status report without last marker");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != rde_pkg::ST_ELEM |-> rsp_element == '0)
    else $error("status report with nonzero element");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind reversible_deque_engine_unit rde_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_element (rsp.element),
  .rsp_last    (rsp.last)
);
